[sv/cax_pkg.sv]
// ----------------------------------------------------------------------------
// cax_pkg
// shared types and constants of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cax_pkg;

   // default part format, signed q8.8
   localparam int DEF_PART_WIDTH = 16;
   localparam int DEF_FRAC_BITS  = 8;

   // request queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 4;

   // request mode codes on the port
   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_EQ  = 3'd4;
   localparam logic [2:0] MODE_NE  = 3'd5;

   // internal operation class
   typedef enum logic [2:0] {
      OP_NOP,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_EQ,
      OP_NE
   } op_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic   vld;
      op_type op;
   } head_type;

endpackage

[sv/cax_front.sv]
// ----------------------------------------------------------------------------
// cax_front
// accepts requests, classifies the mode and queues them for the back end
// ----------------------------------------------------------------------------
module cax_front
   import cax_pkg::*;
#(
   parameter int PART_WIDTH = DEF_PART_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_mode,
   input  logic signed [PART_WIDTH-1:0] req_a_real,
   input  logic signed [PART_WIDTH-1:0] req_a_imag,
   input  logic signed [PART_WIDTH-1:0] req_b_real,
   input  logic signed [PART_WIDTH-1:0] req_b_imag,
   input  logic                         head_take,
   output head_type                     head,
   output logic signed [PART_WIDTH-1:0] head_a_real,
   output logic signed [PART_WIDTH-1:0] head_a_imag,
   output logic signed [PART_WIDTH-1:0] head_b_real,
   output logic signed [PART_WIDTH-1:0] head_b_imag
);

   localparam int PW      = PART_WIDTH;
   localparam int OP_W    = $bits(op_type);
   localparam int ENTRY_W = OP_W + 4 * PW;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

   op_type             op_dec;
   logic [ENTRY_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] head_entry;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   // mode decode
   always_comb begin
      unique case (req_mode)
         MODE_ADD: op_dec = OP_ADD;
         MODE_SUB: op_dec = OP_SUB;
         MODE_MUL: op_dec = OP_MUL;
         MODE_DIV: op_dec = OP_DIV;
         MODE_EQ:  op_dec = OP_EQ;
         MODE_NE:  op_dec = OP_NE;
         default:  op_dec = OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = (count_ff != '0) && head_take;

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= {op_dec, req_a_real, req_a_imag, req_b_real, req_b_imag};
      end
   end

   assign head_entry  = queue_ff[rd_ptr_ff];
   assign head.vld    = (count_ff != '0);
   assign head.op     = op_type'(head_entry[ENTRY_W-1 -: OP_W]);
   assign head_a_real = head_entry[4*PW-1 -: PW];
   assign head_a_imag = head_entry[3*PW-1 -: PW];
   assign head_b_real = head_entry[2*PW-1 -: PW];
   assign head_b_imag = head_entry[PW-1:0];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

[sv/cax_back.sv]
// ----------------------------------------------------------------------------
// cax_back
// pipelined datapath: products, sums, restoring divider, saturation
// ----------------------------------------------------------------------------
module cax_back
   import cax_pkg::*;
#(
   parameter int PART_WIDTH = DEF_PART_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  head_type                     head,
   input  logic signed [PART_WIDTH-1:0] head_a_real,
   input  logic signed [PART_WIDTH-1:0] head_a_imag,
   input  logic signed [PART_WIDTH-1:0] head_b_real,
   input  logic signed [PART_WIDTH-1:0] head_b_imag,
   output logic                         head_take,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [PART_WIDTH-1:0] rsp_res_real,
   output logic signed [PART_WIDTH-1:0] rsp_res_imag,
   output logic                         rsp_truth,
   output logic                         rsp_div_zero,
   output logic                         rsp_overflow
);

   localparam int PW = PART_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int MW = 2 * PW;
   localparam int SW = MW + 1;
   localparam int RW = 3 * PW + FB + 2;
   localparam int NS = PW + 1;

   localparam logic [PW-1:0] PMAX_P = {1'b0, {(PW-1){1'b1}}};
   localparam logic [PW-1:0] PMIN_P = {1'b1, {(PW-1){1'b0}}};
   localparam logic [MW-1:0] PMAX_M = {{PW{1'b0}}, PMAX_P};

   // returns {overflow, value}
   function automatic logic [PW:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
      logic [PW:0] r;
      if (neg) begin
         if (mag > PMAX_M + MW'(1)) r = {1'b1, PMIN_P};
         else r = {1'b0, (~mag[PW-1:0]) + PW'(1)};
      end else begin
         if (mag > PMAX_M) r = {1'b1, PMAX_P};
         else r = {1'b0, mag[PW-1:0]};
      end
      return r;
   endfunction

   function automatic logic [MW-1:0] absv(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] n;
      n = -v;
      return v[SW-1] ? n[MW-1:0] : v[MW-1:0];
   endfunction

   logic adv;

   // stage 0: products and the results of add, subtract and compare
   logic                 s0_vld_ff, s0_vld_in;
   op_type               s0_op_ff, s0_op_in;
   logic signed [MW-1:0] s0_p_rr_ff, s0_p_rr_in, s0_p_ii_ff, s0_p_ii_in;
   logic signed [MW-1:0] s0_p_ri_ff, s0_p_ri_in, s0_p_ir_ff, s0_p_ir_in;
   logic signed [MW-1:0] s0_d_rr_ff, s0_d_rr_in, s0_d_ii_ff, s0_d_ii_in;
   logic [PW-1:0]        s0_res_r_ff, s0_res_r_in, s0_res_i_ff, s0_res_i_in;
   logic                 s0_truth_ff, s0_truth_in, s0_ovf_ff, s0_ovf_in;
   logic signed [PW:0]   as_r, as_i;
   logic                 as_ovf_r, as_ovf_i;

   assign adv       = !rsp_valid || rsp_ready;
   assign head_take = adv;

   assign s0_vld_in  = head.vld;
   assign s0_op_in   = head.op;
   assign s0_p_rr_in = head_a_real * head_b_real;
   assign s0_p_ii_in = head_a_imag * head_b_imag;
   assign s0_p_ri_in = head_a_real * head_b_imag;
   assign s0_p_ir_in = head_a_imag * head_b_real;
   assign s0_d_rr_in = head_b_real * head_b_real;
   assign s0_d_ii_in = head_b_imag * head_b_imag;

   assign as_r = (head.op == OP_SUB)
      ? {head_a_real[PW-1], head_a_real} - {head_b_real[PW-1], head_b_real}
      : {head_a_real[PW-1], head_a_real} + {head_b_real[PW-1], head_b_real};
   assign as_i = (head.op == OP_SUB)
      ? {head_a_imag[PW-1], head_a_imag} - {head_b_imag[PW-1], head_b_imag}
      : {head_a_imag[PW-1], head_a_imag} + {head_b_imag[PW-1], head_b_imag};
   assign as_ovf_r = as_r[PW] ^ as_r[PW-1];
   assign as_ovf_i = as_i[PW] ^ as_i[PW-1];

   always_comb begin
      s0_res_r_in = '0;
      s0_res_i_in = '0;
      s0_truth_in = 1'b0;
      s0_ovf_in   = 1'b0;
      case (head.op) inside
         OP_ADD, OP_SUB: begin
            s0_res_r_in = as_ovf_r ? (as_r[PW] ? PMIN_P : PMAX_P) : as_r[PW-1:0];
            s0_res_i_in = as_ovf_i ? (as_i[PW] ? PMIN_P : PMAX_P) : as_i[PW-1:0];
            s0_ovf_in   = as_ovf_r || as_ovf_i;
         end
         OP_EQ: s0_truth_in = (head_a_real == head_b_real) && (head_a_imag == head_b_imag);
         OP_NE: s0_truth_in = (head_a_real != head_b_real) || (head_a_imag != head_b_imag);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= s0_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_op_ff    <= s0_op_in;
         s0_p_rr_ff  <= s0_p_rr_in;
         s0_p_ii_ff  <= s0_p_ii_in;
         s0_p_ri_ff  <= s0_p_ri_in;
         s0_p_ir_ff  <= s0_p_ir_in;
         s0_d_rr_ff  <= s0_d_rr_in;
         s0_d_ii_ff  <= s0_d_ii_in;
         s0_res_r_ff <= s0_res_r_in;
         s0_res_i_ff <= s0_res_i_in;
         s0_truth_ff <= s0_truth_in;
         s0_ovf_ff   <= s0_ovf_in;
      end
   end

   // chain index 0 holds sums and the multiply result, then one stage for the
   // range check and one stage per quotient bit
   logic [NS:0]   ch_vld_ff, ch_vld_in;
   op_type        ch_op_ff    [NS+1], ch_op_in    [NS+1];
   logic [PW-1:0] ch_res_r_ff [NS+1], ch_res_r_in [NS+1];
   logic [PW-1:0] ch_res_i_ff [NS+1], ch_res_i_in [NS+1];
   logic          ch_truth_ff [NS+1], ch_truth_in [NS+1];
   logic          ch_ovf_ff   [NS+1], ch_ovf_in   [NS+1];
   logic          ch_dz_ff    [NS+1], ch_dz_in    [NS+1];
   logic          ch_neg_r_ff [NS+1], ch_neg_r_in [NS+1];
   logic          ch_neg_i_ff [NS+1], ch_neg_i_in [NS+1];
   logic [MW-1:0] ch_den_ff   [NS+1], ch_den_in   [NS+1];
   logic [RW-1:0] ch_rem_r_ff [NS+1], ch_rem_r_in [NS+1];
   logic [RW-1:0] ch_rem_i_ff [NS+1], ch_rem_i_in [NS+1];
   logic [PW-1:0] ch_q_r_ff   [NS+1], ch_q_r_in   [NS+1];
   logic [PW-1:0] ch_q_i_ff   [NS+1], ch_q_i_in   [NS+1];
   logic          ch_big_r_ff [NS+1], ch_big_r_in [NS+1];
   logic          ch_big_i_ff [NS+1], ch_big_i_in [NS+1];

   logic signed [SW-1:0] mul_nr, mul_ni, div_nr, div_ni;
   logic [MW-1:0]        den_sum;
   logic [PW:0]          mul_sr, mul_si;

   assign mul_nr  = SW'(s0_p_rr_ff) - SW'(s0_p_ii_ff);
   assign mul_ni  = SW'(s0_p_ri_ff) + SW'(s0_p_ir_ff);
   assign div_nr  = SW'(s0_p_rr_ff) + SW'(s0_p_ii_ff);
   assign div_ni  = SW'(s0_p_ir_ff) - SW'(s0_p_ri_ff);
   assign den_sum = $unsigned(s0_d_rr_ff) + $unsigned(s0_d_ii_ff);
   assign mul_sr  = sat_mag(mul_nr[SW-1], absv(mul_nr) >> FB);
   assign mul_si  = sat_mag(mul_ni[SW-1], absv(mul_ni) >> FB);

   assign ch_vld_in[0]   = s0_vld_ff;
   assign ch_op_in[0]    = s0_op_ff;
   assign ch_res_r_in[0] = (s0_op_ff == OP_MUL) ? mul_sr[PW-1:0] : s0_res_r_ff;
   assign ch_res_i_in[0] = (s0_op_ff == OP_MUL) ? mul_si[PW-1:0] : s0_res_i_ff;
   assign ch_truth_in[0] = s0_truth_ff;
   assign ch_ovf_in[0]   = (s0_op_ff == OP_MUL) ? (mul_sr[PW] || mul_si[PW]) : s0_ovf_ff;
   assign ch_dz_in[0]    = (den_sum == '0);
   assign ch_neg_r_in[0] = div_nr[SW-1];
   assign ch_neg_i_in[0] = div_ni[SW-1];
   assign ch_den_in[0]   = den_sum;
   assign ch_rem_r_in[0] = RW'(absv(div_nr)) << FB;
   assign ch_rem_i_in[0] = RW'(absv(div_ni)) << FB;
   assign ch_q_r_in[0]   = '0;
   assign ch_q_i_in[0]   = '0;
   assign ch_big_r_in[0] = 1'b0;
   assign ch_big_i_in[0] = 1'b0;

   for (genvar k = 1; k <= NS; k++) begin : g_div
      logic [RW-1:0] dsh;
      assign ch_vld_in[k]   = ch_vld_ff[k-1];
      assign ch_op_in[k]    = ch_op_ff[k-1];
      assign ch_res_r_in[k] = ch_res_r_ff[k-1];
      assign ch_res_i_in[k] = ch_res_i_ff[k-1];
      assign ch_truth_in[k] = ch_truth_ff[k-1];
      assign ch_ovf_in[k]   = ch_ovf_ff[k-1];
      assign ch_dz_in[k]    = ch_dz_ff[k-1];
      assign ch_neg_r_in[k] = ch_neg_r_ff[k-1];
      assign ch_neg_i_in[k] = ch_neg_i_ff[k-1];
      assign ch_den_in[k]   = ch_den_ff[k-1];
      if (k == 1) begin : g_range
         // quotient of 2^PW or more saturates in any case
         assign dsh            = RW'(ch_den_ff[0]) << PW;
         assign ch_big_r_in[k] = (ch_rem_r_ff[0] >= dsh);
         assign ch_big_i_in[k] = (ch_rem_i_ff[0] >= dsh);
         assign ch_rem_r_in[k] = ch_rem_r_ff[0];
         assign ch_rem_i_in[k] = ch_rem_i_ff[0];
         assign ch_q_r_in[k]   = '0;
         assign ch_q_i_in[k]   = '0;
      end else begin : g_bit
         localparam int BI = NS - k;
         logic take_r, take_i;
         assign dsh            = RW'(ch_den_ff[k-1]) << BI;
         assign take_r         = (ch_rem_r_ff[k-1] >= dsh);
         assign take_i         = (ch_rem_i_ff[k-1] >= dsh);
         assign ch_big_r_in[k] = ch_big_r_ff[k-1];
         assign ch_big_i_in[k] = ch_big_i_ff[k-1];
         assign ch_rem_r_in[k] = take_r ? ch_rem_r_ff[k-1] - dsh : ch_rem_r_ff[k-1];
         assign ch_rem_i_in[k] = take_i ? ch_rem_i_ff[k-1] - dsh : ch_rem_i_ff[k-1];
         assign ch_q_r_in[k]   = ch_q_r_ff[k-1] | (PW'(take_r) << BI);
         assign ch_q_i_in[k]   = ch_q_i_ff[k-1] | (PW'(take_i) << BI);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_vld_ff <= '0;
      end else if (adv) begin
         ch_vld_ff <= ch_vld_in;
      end
   end

   for (genvar k = 0; k <= NS; k++) begin : g_ch_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            ch_op_ff[k]    <= ch_op_in[k];
            ch_res_r_ff[k] <= ch_res_r_in[k];
            ch_res_i_ff[k] <= ch_res_i_in[k];
            ch_truth_ff[k] <= ch_truth_in[k];
            ch_ovf_ff[k]   <= ch_ovf_in[k];
            ch_dz_ff[k]    <= ch_dz_in[k];
            ch_neg_r_ff[k] <= ch_neg_r_in[k];
            ch_neg_i_ff[k] <= ch_neg_i_in[k];
            ch_den_ff[k]   <= ch_den_in[k];
            ch_rem_r_ff[k] <= ch_rem_r_in[k];
            ch_rem_i_ff[k] <= ch_rem_i_in[k];
            ch_q_r_ff[k]   <= ch_q_r_in[k];
            ch_q_i_ff[k]   <= ch_q_i_in[k];
            ch_big_r_ff[k] <= ch_big_r_in[k];
            ch_big_i_ff[k] <= ch_big_i_in[k];
         end
      end
   end

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_res_r_ff, rsp_res_r_in, rsp_res_i_ff, rsp_res_i_in;
   logic          rsp_truth_ff, rsp_truth_in, rsp_dz_ff, rsp_dz_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic [PW:0]   div_sr, div_si;

   assign div_sr = ch_big_r_ff[NS]
      ? {1'b1, (ch_neg_r_ff[NS] ? PMIN_P : PMAX_P)}
      : sat_mag(ch_neg_r_ff[NS], MW'(ch_q_r_ff[NS]));
   assign div_si = ch_big_i_ff[NS]
      ? {1'b1, (ch_neg_i_ff[NS] ? PMIN_P : PMAX_P)}
      : sat_mag(ch_neg_i_ff[NS], MW'(ch_q_i_ff[NS]));

   assign rsp_valid_in = ch_vld_ff[NS];

   always_comb begin
      rsp_res_r_in = ch_res_r_ff[NS];
      rsp_res_i_in = ch_res_i_ff[NS];
      rsp_truth_in = ch_truth_ff[NS];
      rsp_dz_in    = 1'b0;
      rsp_ovf_in   = ch_ovf_ff[NS];
      if (ch_op_ff[NS] == OP_DIV) begin
         rsp_truth_in = 1'b0;
         if (ch_dz_ff[NS]) begin
            rsp_res_r_in = '0;
            rsp_res_i_in = '0;
            rsp_dz_in    = 1'b1;
            rsp_ovf_in   = 1'b0;
         end else begin
            rsp_res_r_in = div_sr[PW-1:0];
            rsp_res_i_in = div_si[PW-1:0];
            rsp_ovf_in   = div_sr[PW] || div_si[PW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_res_r_ff <= rsp_res_r_in;
         rsp_res_i_ff <= rsp_res_i_in;
         rsp_truth_ff <= rsp_truth_in;
         rsp_dz_ff    <= rsp_dz_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_real = rsp_res_r_ff;
   assign rsp_res_imag = rsp_res_i_ff;
   assign rsp_truth    = rsp_truth_ff;
   assign rsp_div_zero = rsp_dz_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |->
         rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_overflow && !rsp_truth)
      else $error("zero divisor result not clean");

   a_truth_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truth |->
         rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_overflow)
      else $error("compare result carries arithmetic bits");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ch_vld_ff) && $stable(s0_vld_ff))
      else $error("pipeline moved during stall");

endmodule

[sv/complex_alu_fixed.sv]
// ----------------------------------------------------------------------------
// complex_alu_fixed
// complex add, subtract, multiply, divide and compare on signed fixed point
// ----------------------------------------------------------------------------
// One request per clock is accepted and one response per clock is delivered
// when rsp_ready stays high. Every request, whatever its mode, passes through
// the same fixed pipeline: the request queue entry written at the accepting
// edge, a product stage, a sum stage, one divider range stage, PART_WIDTH
// divider stages (one quotient bit each) and the output register. The divider
// chain, which grows with PART_WIDTH, sets the pipeline depth; the default
// format is Q8.8. Throughput is one request per cycle while rsp_ready stays
// high; a stalled response freezes the back pipeline while the queue keeps
// accepting until it holds QUEUE_DEPTH requests. Subtract and divide return
// a-b and a/b. Multiply and divide results are truncated toward zero and
// saturated with rsp_overflow set; a zero divisor gives zero parts with
// rsp_div_zero set. Unused modes return all zero fields.
// ----------------------------------------------------------------------------
module complex_alu_fixed
   import cax_pkg::*;
#(
   parameter int PART_WIDTH = DEF_PART_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_mode,
   input  logic signed [PART_WIDTH-1:0] req_a_real,
   input  logic signed [PART_WIDTH-1:0] req_a_imag,
   input  logic signed [PART_WIDTH-1:0] req_b_real,
   input  logic signed [PART_WIDTH-1:0] req_b_imag,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [PART_WIDTH-1:0] rsp_res_real,
   output logic signed [PART_WIDTH-1:0] rsp_res_imag,
   output logic                         rsp_truth,
   output logic                         rsp_div_zero,
   output logic                         rsp_overflow
);

   // queue head handed from front to back
   head_type                     head;
   logic signed [PART_WIDTH-1:0] head_a_real;
   logic signed [PART_WIDTH-1:0] head_a_imag;
   logic signed [PART_WIDTH-1:0] head_b_real;
   logic signed [PART_WIDTH-1:0] head_b_imag;
   // back end pops the head whenever its pipeline advances
   logic                         head_take;

   // front: mode decode and request queue
   cax_front #(
      .PART_WIDTH (PART_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_a_real  (req_a_real),
      .req_a_imag  (req_a_imag),
      .req_b_real  (req_b_real),
      .req_b_imag  (req_b_imag),
      .head_take   (head_take),
      .head        (head),
      .head_a_real (head_a_real),
      .head_a_imag (head_a_imag),
      .head_b_real (head_b_real),
      .head_b_imag (head_b_imag)
   );

   // back: arithmetic pipeline and output register
   cax_back #(
      .PART_WIDTH (PART_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_a_real  (head_a_real),
      .head_a_imag  (head_a_imag),
      .head_b_real  (head_b_real),
      .head_b_imag  (head_b_imag),
      .head_take    (head_take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res_real (rsp_res_real),
      .rsp_res_imag (rsp_res_imag),
      .rsp_truth    (rsp_truth),
      .rsp_div_zero (rsp_div_zero),
      .rsp_overflow (rsp_overflow)
   );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the complex arithmetic unit against its own predictor: directed
// corner requests for every mode, then random requests under changing idle
// patterns on both channels and one long response stall
// ----------------------------------------------------------------------------
module testbench
   import cax_pkg::*;
();

   localparam int PW = 16;
   localparam int FB = 8;
   localparam int LATENCY = PW + 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [PW-1:0] PMAX = 16'sh7fff;
   localparam logic signed [PW-1:0] PMIN = 16'sh8000;

   // one expected response
   typedef struct {
      logic signed [PW-1:0] re;
      logic signed [PW-1:0] im;
      logic                 truth;
      logic                 dz;
      logic                 ovf;
   } alu_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_mode = MODE_ADD;
   logic signed [PW-1:0] req_a_real = '0, req_a_imag = '0;
   logic signed [PW-1:0] req_b_real = '0, req_b_imag = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PW-1:0] rsp_res_real, rsp_res_imag;
   logic rsp_truth, rsp_div_zero, rsp_overflow;

   alu_result_t pending_results[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;

   complex_alu_fixed dut (.*);

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("complex_alu_fixed: mismatch");
         $finish;
      end
   end

   // saturate an exact value to the part range
   function automatic logic signed [PW-1:0] clamp_part(longint v, ref logic ovf);
      if (v > longint'(PMAX)) begin
         ovf = 1'b1;
         return PMAX;
      end
      if (v < longint'(PMIN)) begin
         ovf = 1'b1;
         return PMIN;
      end
      return v[PW-1:0];
   endfunction

   // exact numerator shifted left by fraction bits over den, toward zero
   function automatic longint div_toward_zero(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FB) / den;
      return (num < 0) ? -q : q;
   endfunction

   // expected response of the arithmetic unit for one request
   function automatic alu_result_t complex_result(logic [2:0] mode,
         logic signed [PW-1:0] ar, logic signed [PW-1:0] ai,
         logic signed [PW-1:0] br, logic signed [PW-1:0] bi);
      alu_result_t r;
      longint nr, ni, den;
      logic ovf;
      r = '{default: '0};
      ovf = 1'b0;
      case (mode)
         MODE_ADD: begin
            r.re = clamp_part(longint'(ar) + longint'(br), ovf);
            r.im = clamp_part(longint'(ai) + longint'(bi), ovf);
         end
         MODE_SUB: begin
            r.re = clamp_part(longint'(ar) - longint'(br), ovf);
            r.im = clamp_part(longint'(ai) - longint'(bi), ovf);
         end
         MODE_MUL: begin
            // truncate toward zero, not floor
            nr = longint'(ar) * br - longint'(ai) * bi;
            ni = longint'(ar) * bi + longint'(ai) * br;
            r.re = clamp_part((nr < 0) ? -((-nr) >>> FB) : (nr >>> FB), ovf);
            r.im = clamp_part((ni < 0) ? -((-ni) >>> FB) : (ni >>> FB), ovf);
         end
         MODE_DIV: begin
            den = longint'(br) * br + longint'(bi) * bi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               nr = longint'(ar) * br + longint'(ai) * bi;
               ni = longint'(ai) * br - longint'(ar) * bi;
               r.re = clamp_part(div_toward_zero(nr, den), ovf);
               r.im = clamp_part(div_toward_zero(ni, den), ovf);
            end
         end
         MODE_EQ: r.truth = (ar == br) && (ai == bi);
         MODE_NE: r.truth = (ar != br) || (ai != bi);
         default: ;
      endcase
      r.ovf = ovf;
      return r;
   endfunction

   // send one request, idling beforehand at the current rate
   task automatic send_request(logic [2:0] mode, logic signed [PW-1:0] ar,
         logic signed [PW-1:0] ai, logic signed [PW-1:0] br,
         logic signed [PW-1:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_a_real <= ar;
      req_a_imag <= ai;
      req_b_real <= br;
      req_b_imag <= bi;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(complex_result(mode, ar, ai, br, bi));
      @(negedge clock);
   endtask

   // response ready, idles at random or holds off for a counted stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      alu_result_t exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected response re=%h im=%h", $time,
               rsp_res_real, rsp_res_imag);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_res_real !== exp_r.re) begin
               errors++;
               $display("%0t res_real expected %h actual %h", $time, exp_r.re,
                  rsp_res_real);
            end
            if (rsp_res_imag !== exp_r.im) begin
               errors++;
               $display("%0t res_imag expected %h actual %h", $time, exp_r.im,
                  rsp_res_imag);
            end
            if (rsp_truth !== exp_r.truth) begin
               errors++;
               $display("%0t truth expected %b actual %b", $time, exp_r.truth,
                  rsp_truth);
            end
            if (rsp_div_zero !== exp_r.dz) begin
               errors++;
               $display("%0t div_zero expected %b actual %b", $time, exp_r.dz,
                  rsp_div_zero);
            end
            if (rsp_overflow !== exp_r.ovf) begin
               errors++;
               $display("%0t overflow expected %b actual %b", $time, exp_r.ovf,
                  rsp_overflow);
            end
         end
      end
   end

   // random part value, biased toward the extremes and small numbers
   function automatic logic signed [PW-1:0] pick_part();
      case ($urandom_range(9))
         0: return PMAX;
         1: return PMIN;
         2: return '0;
         3: return PW'($urandom_range(512)) - 16'sd256;
         default: return PW'($urandom);
      endcase
   endfunction

   // corner requests for every mode
   task automatic test_directed();
      send_request(MODE_ADD, PMAX, PMIN, 16'sd1, -16'sd1);
      send_request(MODE_ADD, 16'sh0180, -16'sh0040, 16'sh0100, 16'sh0020);
      send_request(MODE_SUB, PMIN, PMAX, 16'sd1, -16'sd1);
      send_request(MODE_SUB, 16'sh0300, 16'sh0100, 16'sh0100, 16'sh0200);
      send_request(MODE_MUL, PMAX, PMAX, PMAX, PMAX);
      send_request(MODE_MUL, PMIN, PMIN, PMIN, PMIN);
      send_request(MODE_MUL, 16'sh0100, 16'sh0100, 16'sh0100, -16'sh0100);
      send_request(MODE_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
      send_request(MODE_DIV, 16'sh0100, 16'sh0000, 16'sd0, 16'sd0);
      send_request(MODE_DIV, PMIN, PMIN, 16'sd1, 16'sd0);
      send_request(MODE_DIV, 16'sh0200, 16'sh0100, 16'sh0100, 16'sh0100);
      send_request(MODE_DIV, -16'sd1, 16'sd1, PMAX, PMIN);
      send_request(MODE_DIV, PMAX, PMAX, 16'sd1, 16'sd1);
      send_request(MODE_EQ, 16'sd5, -16'sd7, 16'sd5, -16'sd7);
      send_request(MODE_EQ, 16'sd5, -16'sd7, 16'sd5, -16'sd6);
      send_request(MODE_NE, PMIN, PMAX, PMIN, PMAX);
      send_request(MODE_NE, PMIN, PMAX, PMAX, PMAX);
      send_request(3'd6, PMAX, PMAX, PMIN, PMIN);
      send_request(3'd7, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
   endtask

   // random requests of every mode, equal operands for compares now and then
   task automatic test_random(int count);
      logic [2:0] mode;
      logic signed [PW-1:0] ar, ai, br, bi;
      repeat (count) begin
         mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5));
         ar = pick_part();
         ai = pick_part();
         br = pick_part();
         bi = pick_part();
         if ((mode == MODE_EQ || mode == MODE_NE) && $urandom_range(1)) begin
            br = ar;
            bi = ai;
         end
         if (mode == MODE_DIV && $urandom_range(9) == 0) begin
            br = '0;
            bi = '0;
         end
         send_request(mode, ar, ai, br, bi);
      end
   endtask

   // long response stall while requests keep coming, fills the queue
   task automatic test_back_pressure();
      send_idle_pct = 0;
      hold_off_cycles = 200;
      test_random(60);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      send_idle_pct = 29;
      recv_idle_pct = 55;
      test_random(380);
      send_idle_pct = 55;
      recv_idle_pct = 29;
      test_random(380);
      recv_idle_pct = 0;
      test_back_pressure();
      send_idle_pct = 0;
      test_random(320);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      if (errors == 0)
         $display("complex_alu_fixed: match");
      else
         $display("complex_alu_fixed: mismatch");
      $finish;
   end

endmodule
